// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the sender engine.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every clock edge out of reset.
`define TSWR_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition never holds out of reset.
`define TSWR_NEVER(name, clk, rst_n, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ----- hdl/tswr_pkg.sv -----
// ----------------------------------------------------------------------------
// tswr_pkg
// Types and constants shared by the TCP sender window/retransmit engine.
// ----------------------------------------------------------------------------
package tswr_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 64;

  // Input item kinds
  localparam logic [2:0] KIND_WRITE = 3'd0;
  localparam logic [2:0] KIND_FILL  = 3'd1;
  localparam logic [2:0] KIND_ACK   = 3'd2;
  localparam logic [2:0] KIND_TICK  = 3'd3;
  localparam logic [2:0] KIND_EMPTY = 3'd4;

  // Configuration register indexes
  localparam logic [1:0] CFG_INITIAL_SEQNO   = 2'd0;
  localparam logic [1:0] CFG_INITIAL_TIMEOUT = 2'd1;
  localparam logic [1:0] CFG_MAX_PAYLOAD     = 2'd2;
  localparam logic [1:0] CFG_STREAM_CAPACITY = 2'd3;

  // Register reset values
  localparam logic [31:0] RST_INITIAL_SEQNO   = 32'd0;
  localparam logic [15:0] RST_INITIAL_TIMEOUT = 16'd1000;
  localparam logic [15:0] RST_MAX_PAYLOAD     = 16'd1000;
  localparam logic [31:0] RST_STREAM_CAPACITY = 32'd65535;

  typedef struct packed {
    logic [31:0] initial_seqno;
    logic [15:0] initial_timeout_ms;
    logic [15:0] max_payload;
    logic [31:0] stream_capacity;
  } cfg_t;

  // One outstanding segment
  typedef struct packed {
    logic [47:0] start;
    logic        fin;
    logic        syn;
    logic [15:0] len;
  } seg_entry_t;

  // One result item
  typedef struct packed {
    logic        seg_valid;
    logic [31:0] seqno;
    logic [47:0] stream_offset;
    logic [15:0] payload_len;
    logic        syn_flag;
    logic        fin_flag;
    logic        retransmit;
    logic        last;
    logic [16:0] in_flight;
    logic [15:0] retx_count;
  } res_t;

endpackage

// ----- hdl/tswr_seg_mem.sv -----
// ----------------------------------------------------------------------------
// tswr_seg_mem
// Outstanding segment store: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module tswr_seg_mem #(
  parameter  int unsigned DEPTH = tswr_pkg::QUEUE_DEPTH_DEF,
  localparam int unsigned AW    = $clog2(DEPTH)
) (
  input  logic                   clk_i,
  input  logic                   we_i,
  input  logic [AW-1:0]          waddr_i,
  input  tswr_pkg::seg_entry_t   wdata_i,
  input  logic                   re_i,
  input  logic [AW-1:0]          raddr_i,
  output tswr_pkg::seg_entry_t   rdata_o
);
  import tswr_pkg::*;

  seg_entry_t mem_q [DEPTH];
  seg_entry_t rdata_q;

  // Write one entry
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read one entry, hold data until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/tswr_ctrl.sv -----
// ----------------------------------------------------------------------------
// tswr_ctrl
// Sequencer: sequence-space state, fill/ack/tick handling, descriptor readout.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tswr_ctrl #(
  parameter  int unsigned DEPTH = tswr_pkg::QUEUE_DEPTH_DEF,
  localparam int unsigned AW    = $clog2(DEPTH)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  tswr_pkg::cfg_t         cfg_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [2:0]             kind_i,
  input  logic [15:0]            write_count_i,
  input  logic                   write_end_i,
  input  logic [31:0]            ack_number_i,
  input  logic [15:0]            window_advert_i,
  input  logic [31:0]            elapsed_ms_i,
  output logic                   res_valid_o,
  output tswr_pkg::res_t         res_o,
  input  logic                   res_ready_i,
  output logic                   mem_we_o,
  output logic [AW-1:0]          mem_waddr_o,
  output tswr_pkg::seg_entry_t   mem_wdata_o,
  output logic                   mem_re_o,
  output logic [AW-1:0]          mem_raddr_o,
  input  tswr_pkg::seg_entry_t   mem_rdata_i
);
  import tswr_pkg::*;

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [CW:0]   DEPTH_W = (CW + 1)'(DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_WR       = 4'd1;
  localparam logic [3:0] ST_FILL     = 4'd2;
  localparam logic [3:0] ST_ACK_DIFF = 4'd3;
  localparam logic [3:0] ST_ACK_ABS  = 4'd4;
  localparam logic [3:0] ST_POP_RD   = 4'd5;
  localparam logic [3:0] ST_POP_CHK  = 4'd6;
  localparam logic [3:0] ST_ACK_END  = 4'd7;
  localparam logic [3:0] ST_TICK_ADD = 4'd8;
  localparam logic [3:0] ST_TICK_CHK = 4'd9;
  localparam logic [3:0] ST_DR_RD    = 4'd10;
  localparam logic [3:0] ST_DR_OUT   = 4'd11;
  localparam logic [3:0] ST_EMPTY    = 4'd12;
  localparam logic [3:0] ST_STATUS   = 4'd13;
  localparam logic [3:0] ST_FILL_END = 4'd14;

  function automatic logic [AW-1:0] idx_add(input logic [AW-1:0] a, input logic [CW-1:0] b);
    logic [CW:0] s;
    s = (CW + 1)'(a) + (CW + 1)'(b);
    if (s >= DEPTH_W) s = s - DEPTH_W;
    return s[AW-1:0];
  endfunction

  logic [3:0]  state_q, state_d;
  logic [15:0] wr_cnt_q, wr_cnt_d;
  logic        wr_end_q, wr_end_d;
  logic [31:0] ack_q, ack_d;
  logic [15:0] adv_q, adv_d;
  logic [31:0] elapsed_q, elapsed_d;
  logic [31:0] buf_q, buf_d;
  logic        ended_q, ended_d;
  logic [47:0] next_q, next_d;
  logic [16:0] out_q, out_d;
  logic [15:0] win_q, win_d;
  logic        syn_sent_q, syn_sent_d;
  logic        fin_sent_q, fin_sent_d;
  logic [31:0] timer_q, timer_d;
  logic [31:0] timeout_q, timeout_d;
  logic [15:0] retx_q, retx_d;
  logic [AW-1:0] head_q, head_d;
  logic [CW-1:0] count_q, count_d;
  logic [31:0] diff_q, diff_d;
  logic [47:0] abs_q, abs_d;
  logic [CW-1:0] nemit_q, nemit_d;
  logic [AW-1:0] first_q, first_d;
  logic [AW-1:0] ptr_q, ptr_d;
  logic [CW-1:0] left_q, left_d;
  logic        rflag_q, rflag_d;

  // Fill step terms
  logic [16:0] f_win, f_room;
  logic        f_syn, f_fin, f_go, f_brk;
  logic [15:0] f_pay;
  logic [16:0] f_len;
  logic [AW-1:0] tail;
  // Other datapath terms
  logic [31:0] w_space, w_add;
  logic [32:0] a_back, t_sum;
  logic [16:0] p_len;
  logic [48:0] p_end;

  assign tail = idx_add(head_q, count_q);

  always_comb begin
    f_win  = (win_q == 16'd0) ? 17'd1 : {1'b0, win_q};
    f_syn  = !syn_sent_q;
    f_room = f_win - out_q - {16'd0, f_syn};
    f_pay  = cfg_i.max_payload;
    if ({15'd0, f_room} < {16'd0, f_pay}) f_pay = f_room[15:0];
    if (buf_q < {16'd0, f_pay}) f_pay = buf_q[15:0];
    f_fin  = !fin_sent_q && ended_q && (buf_q == {16'd0, f_pay}) &&
             (f_room > {1'b0, f_pay});
    f_brk  = (f_pay == 16'd0) && !f_syn && !f_fin;
    f_go   = (f_win > out_q) && (count_q != DEPTH_C) && !f_brk;
    f_len  = {1'b0, f_pay} + {16'd0, f_syn} + {16'd0, f_fin};
  end

  always_comb begin
    w_space = (cfg_i.stream_capacity > buf_q) ? cfg_i.stream_capacity - buf_q : 32'd0;
    w_add   = ({16'd0, wr_cnt_q} < w_space) ? {16'd0, wr_cnt_q} : w_space;
    a_back  = 33'h1_0000_0000 - {1'b0, diff_q};
    t_sum   = {1'b0, timer_q} + {1'b0, elapsed_q};
    p_len   = {1'b0, mem_rdata_i.len} + {16'd0, mem_rdata_i.syn} +
              {16'd0, mem_rdata_i.fin};
    p_end   = {1'b0, mem_rdata_i.start} + {32'd0, p_len};
  end

  // Next-state logic
  always_comb begin
    state_d    = state_q;
    wr_cnt_d   = wr_cnt_q;
    wr_end_d   = wr_end_q;
    ack_d      = ack_q;
    adv_d      = adv_q;
    elapsed_d  = elapsed_q;
    buf_d      = buf_q;
    ended_d    = ended_q;
    next_d     = next_q;
    out_d      = out_q;
    win_d      = win_q;
    syn_sent_d = syn_sent_q;
    fin_sent_d = fin_sent_q;
    timer_d    = timer_q;
    timeout_d  = timeout_q;
    retx_d     = retx_q;
    head_d     = head_q;
    count_d    = count_q;
    diff_d     = diff_q;
    abs_d      = abs_q;
    nemit_d    = nemit_q;
    first_d    = first_q;
    ptr_d      = ptr_q;
    left_d     = left_q;
    rflag_d    = rflag_q;
    in_ready_o = (state_q == ST_IDLE);
    mem_we_o   = 1'b0;
    mem_waddr_o = tail;
    mem_wdata_o = '{start: next_q, fin: f_fin, syn: f_syn, len: f_pay};
    mem_re_o   = 1'b0;
    mem_raddr_o = head_q;
    res_valid_o = 1'b0;
    res_o      = '0;
    res_o.in_flight  = out_q;
    res_o.retx_count = retx_q;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          wr_cnt_d  = write_count_i;
          wr_end_d  = write_end_i;
          ack_d     = ack_number_i;
          adv_d     = window_advert_i;
          elapsed_d = elapsed_ms_i;
          nemit_d   = '0;
          case (kind_i)
            KIND_WRITE: state_d = ST_WR;
            KIND_FILL:  state_d = ST_FILL;
            KIND_ACK:   state_d = ST_ACK_DIFF;
            KIND_TICK:  state_d = ST_TICK_ADD;
            KIND_EMPTY: state_d = ST_EMPTY;
            default:    state_d = ST_STATUS;
          endcase
        end
      end
      ST_WR: begin
        if (!ended_q) buf_d = buf_q + w_add;
        if (wr_end_q) ended_d = 1'b1;
        state_d = ST_STATUS;
      end
      ST_FILL: begin
        // Emit one segment a cycle into the queue
        if (!f_go) begin
          state_d = ST_FILL_END;
        end else begin
          mem_we_o   = 1'b1;
          syn_sent_d = 1'b1;
          if (f_fin) fin_sent_d = 1'b1;
          if (count_q == '0) begin
            timer_d   = 32'd0;
            timeout_d = {16'd0, cfg_i.initial_timeout_ms};
          end
          if (nemit_q == '0) first_d = tail;
          nemit_d = nemit_q + CW'(1);
          count_d = count_q + CW'(1);
          out_d   = out_q + f_len;
          next_d  = next_q + {31'd0, f_len};
          buf_d   = buf_q - {16'd0, f_pay};
          if (f_fin) state_d = ST_FILL_END;
        end
      end
      ST_FILL_END: begin
        if (nemit_q == '0) begin
          state_d = ST_STATUS;
        end else begin
          ptr_d   = first_q;
          left_d  = nemit_q;
          rflag_d = 1'b0;
          state_d = ST_DR_RD;
        end
      end
      ST_ACK_DIFF: begin
        diff_d  = ack_q - (cfg_i.initial_seqno + next_q[31:0]);
        state_d = ST_ACK_ABS;
      end
      ST_ACK_ABS: begin
        // Unwrap the ack; drop acks ahead of the next sequence number or before the initial sequence number
        if (diff_q == 32'd0) begin
          abs_d   = next_q;
          state_d = ST_POP_RD;
        end else if (!diff_q[31]) begin
          state_d = ST_STATUS;
        end else if ({15'd0, a_back} > next_q) begin
          state_d = ST_STATUS;
        end else begin
          abs_d   = next_q - {15'd0, a_back};
          state_d = ST_POP_RD;
        end
      end
      ST_POP_RD: begin
        if (count_q == '0) begin
          state_d = ST_ACK_END;
        end else begin
          mem_re_o = 1'b1;
          state_d  = ST_POP_CHK;
        end
      end
      ST_POP_CHK: begin
        // Pop the head segment if the ack covers it
        if ({1'b0, abs_q} < p_end) begin
          state_d = ST_ACK_END;
        end else begin
          out_d     = out_q - p_len;
          head_d    = idx_add(head_q, CW'(1));
          count_d   = count_q - CW'(1);
          timer_d   = 32'd0;
          timeout_d = {16'd0, cfg_i.initial_timeout_ms};
          state_d   = ST_POP_RD;
        end
      end
      ST_ACK_END: begin
        retx_d  = 16'd0;
        win_d   = adv_q;
        state_d = ST_FILL;
      end
      ST_TICK_ADD: begin
        timer_d = t_sum[32] ? 32'hFFFF_FFFF : t_sum[31:0];
        state_d = ST_TICK_CHK;
      end
      ST_TICK_CHK: begin
        // Resend the oldest segment on expiry and back off unless the window is zero
        if ((count_q != '0) && (timer_q >= timeout_q)) begin
          mem_re_o = 1'b1;
          timer_d  = 32'd0;
          if (win_q != 16'd0) begin
            timeout_d = timeout_q[31] ? 32'hFFFF_FFFF : {timeout_q[30:0], 1'b0};
          end
          if (retx_q != 16'hFFFF) retx_d = retx_q + 16'd1;
          ptr_d   = head_q;
          left_d  = CW'(1);
          rflag_d = 1'b1;
          state_d = ST_DR_OUT;
        end else begin
          state_d = ST_STATUS;
        end
      end
      ST_DR_RD: begin
        mem_re_o    = 1'b1;
        mem_raddr_o = ptr_q;
        state_d     = ST_DR_OUT;
      end
      ST_DR_OUT: begin
        res_valid_o         = 1'b1;
        res_o.seg_valid     = 1'b1;
        res_o.seqno         = cfg_i.initial_seqno + mem_rdata_i.start[31:0];
        res_o.stream_offset = mem_rdata_i.syn ? mem_rdata_i.start :
                              (mem_rdata_i.start == 48'd0) ? 48'd0 :
                              mem_rdata_i.start - 48'd1;
        res_o.payload_len   = mem_rdata_i.len;
        res_o.syn_flag      = mem_rdata_i.syn;
        res_o.fin_flag      = mem_rdata_i.fin;
        res_o.retransmit    = rflag_q;
        res_o.last          = (left_q == CW'(1));
        if (res_ready_i) begin
          ptr_d   = idx_add(ptr_q, CW'(1));
          left_d  = left_q - CW'(1);
          state_d = (left_q == CW'(1)) ? ST_IDLE : ST_DR_RD;
        end
      end
      ST_EMPTY: begin
        res_valid_o         = 1'b1;
        res_o.seg_valid     = 1'b1;
        res_o.seqno         = cfg_i.initial_seqno + next_q[31:0];
        res_o.stream_offset = (next_q == 48'd0) ? 48'd0 : next_q - 48'd1;
        res_o.last          = 1'b1;
        if (res_ready_i) state_d = ST_IDLE;
      end
      ST_STATUS: begin
        res_valid_o = 1'b1;
        res_o.last  = 1'b1;
        if (res_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control and sequence-space state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      buf_q      <= 32'd0;
      ended_q    <= 1'b0;
      next_q     <= 48'd0;
      out_q      <= 17'd0;
      win_q      <= 16'd1;
      syn_sent_q <= 1'b0;
      fin_sent_q <= 1'b0;
      timer_q    <= 32'd0;
      timeout_q  <= {16'd0, RST_INITIAL_TIMEOUT};
      retx_q     <= 16'd0;
      head_q     <= '0;
      count_q    <= '0;
      nemit_q    <= '0;
      left_q     <= '0;
    end else begin
      state_q    <= state_d;
      buf_q      <= buf_d;
      ended_q    <= ended_d;
      next_q     <= next_d;
      out_q      <= out_d;
      win_q      <= win_d;
      syn_sent_q <= syn_sent_d;
      fin_sent_q <= fin_sent_d;
      timer_q    <= timer_d;
      timeout_q  <= timeout_d;
      retx_q     <= retx_d;
      head_q     <= head_d;
      count_q    <= count_d;
      nemit_q    <= nemit_d;
      left_q     <= left_d;
    end
  end

  // Item payload and scratch values
  always_ff @(posedge clk_i) begin
    wr_cnt_q  <= wr_cnt_d;
    wr_end_q  <= wr_end_d;
    ack_q     <= ack_d;
    adv_q     <= adv_d;
    elapsed_q <= elapsed_d;
    diff_q    <= diff_d;
    abs_q     <= abs_d;
    first_q   <= first_d;
    ptr_q     <= ptr_d;
    rflag_q   <= rflag_d;
  end

  `TSWR_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= DEPTH_C, "queue count overflow")
  `TSWR_ASSERT(a_empty_idle, clk_i, rst_ni, (count_q == '0) |-> (out_q == 17'd0),
               "bytes in flight with empty queue")
  `TSWR_NEVER(a_drain_left, clk_i, rst_ni, (state_q == ST_DR_OUT) && (left_q == '0),
              "readout with nothing left")

endmodule

// ----- hdl/tcp_sender_window_retransmit.sv -----
// ----------------------------------------------------------------------------
// tcp_sender_window_retransmit
// TCP sender sequence-space engine with outstanding queue and retransmission.
// ----------------------------------------------------------------------------
//  channel | signals                      | direction
//  in      | in_valid_i / in_ready_o      | item in
//  out     | out_valid_o / out_ready_i    | result out
//  cfg     | cfg_valid_i / cfg_ready_o    | register write in
//
//  Empty and unknown-kind items go straight to the result, writes through ST_WR,
//  ticks and ignored acks through two states. A fill emits one segment per cycle
//  into the queue, then reads each descriptor back from the segment memory and
//  sends it out. An ack pops each covered segment by a read of the segment
//  memory and a check. Reset clears all control state; the segment memory needs
//  no clearing. A stalled output holds the sequencer.
// ----------------------------------------------------------------------------
module tcp_sender_window_retransmit #(
  parameter int unsigned QUEUE_DEPTH = tswr_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  kind_i,
  input  logic [15:0] write_count_i,
  input  logic        write_end_i,
  input  logic [31:0] ack_number_i,
  input  logic [15:0] window_advert_i,
  input  logic [31:0] elapsed_ms_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        seg_valid_o,
  output logic [31:0] seqno_o,
  output logic [47:0] stream_offset_o,
  output logic [15:0] payload_len_o,
  output logic        syn_flag_o,
  output logic        fin_flag_o,
  output logic        retransmit_o,
  output logic        last_o,
  output logic [16:0] in_flight_o,
  output logic [15:0] retx_count_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);
  import tswr_pkg::*;

  localparam int unsigned AW = $clog2(QUEUE_DEPTH);

  cfg_t       cfg_q;
  res_t       res, out_q;
  logic       res_valid, res_ready, out_valid_q;
  logic       mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  seg_entry_t mem_wdata, mem_rdata;

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{initial_seqno: RST_INITIAL_SEQNO,
                 initial_timeout_ms: RST_INITIAL_TIMEOUT,
                 max_payload: RST_MAX_PAYLOAD,
                 stream_capacity: RST_STREAM_CAPACITY};
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_INITIAL_SEQNO:   cfg_q.initial_seqno      <= cfg_data_i;
        CFG_INITIAL_TIMEOUT: cfg_q.initial_timeout_ms <= cfg_data_i[15:0];
        CFG_MAX_PAYLOAD:     cfg_q.max_payload        <= cfg_data_i[15:0];
        CFG_STREAM_CAPACITY: cfg_q.stream_capacity    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  tswr_ctrl #(.DEPTH(QUEUE_DEPTH)) u_ctrl (
    .clk_i, .rst_ni,
    .cfg_i           (cfg_q),
    .in_valid_i, .in_ready_o,
    .kind_i, .write_count_i, .write_end_i, .ack_number_i,
    .window_advert_i, .elapsed_ms_i,
    .res_valid_o     (res_valid),
    .res_o           (res),
    .res_ready_i     (res_ready),
    .mem_we_o        (mem_we),
    .mem_waddr_o     (mem_waddr),
    .mem_wdata_o     (mem_wdata),
    .mem_re_o        (mem_re),
    .mem_raddr_o     (mem_raddr),
    .mem_rdata_i     (mem_rdata)
  );

  tswr_seg_mem #(.DEPTH(QUEUE_DEPTH)) u_mem (
    .clk_i,
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Output register: take a new result when empty or being drained
  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign seg_valid_o     = out_q.seg_valid;
  assign seqno_o         = out_q.seqno;
  assign stream_offset_o = out_q.stream_offset;
  assign payload_len_o   = out_q.payload_len;
  assign syn_flag_o      = out_q.syn_flag;
  assign fin_flag_o      = out_q.fin_flag;
  assign retransmit_o    = out_q.retransmit;
  assign last_o          = out_q.last;
  assign in_flight_o     = out_q.in_flight;
  assign retx_count_o    = out_q.retx_count;

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the TCP sender window/retransmit engine. Drives
// writes, fills, acks, ticks and empty-segment requests with random gaps on
// both channels, predicts every segment descriptor and status result, and
// checks each result field by field against the oldest expectation.
// ----------------------------------------------------------------------------
module tb_top;
  import tswr_pkg::*;

  // Predictor of the sender engine and store of expected results
  class seg_scoreboard;
    longint unsigned iss, init_to, max_pay, capacity;
    longint unsigned buffered, next_abs, outstanding, win_last, timer, timeout;
    longint unsigned retx;
    bit ended, syn_sent, fin_sent;
    longint unsigned q_start[QUEUE_DEPTH_DEF];
    longint unsigned q_pay[QUEUE_DEPTH_DEF];
    bit q_syn[QUEUE_DEPTH_DEF], q_fin[QUEUE_DEPTH_DEF];
    int unsigned head, count;
    res_t expected_q[$];
    res_t batch[$];
    int errors;

    function new();
      errors = 0;
      iss = RST_INITIAL_SEQNO; init_to = RST_INITIAL_TIMEOUT;
      max_pay = RST_MAX_PAYLOAD; capacity = RST_STREAM_CAPACITY;
      buffered = 0; next_abs = 0; outstanding = 0; win_last = 1;
      timer = 0; timeout = init_to; retx = 0;
      ended = 0; syn_sent = 0; fin_sent = 0; head = 0; count = 0;
    endfunction

    function longint unsigned wrap_seq(longint unsigned abs_seq);
      return (iss + abs_seq) & 64'hFFFF_FFFF;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
        CFG_INITIAL_SEQNO:   iss = val;
        CFG_INITIAL_TIMEOUT: init_to = val[15:0];
        CFG_MAX_PAYLOAD:     max_pay = val[15:0];
        CFG_STREAM_CAPACITY: capacity = val;
        default: ;
      endcase
    endfunction

    // Queue one descriptor of the current input
    function void add_seg(bit vld, longint unsigned start, longint unsigned pay,
                          bit syn, bit fin, bit rtx);
      res_t r;
      longint unsigned first;
      r = '0;
      r.seg_valid = vld;
      if (vld) begin
        r.seqno = 32'(wrap_seq(start));
        first = start + syn;
        r.stream_offset = (first == 0) ? 48'd0 : 48'(first - 1);
      end
      r.payload_len = pay[15:0];
      r.syn_flag = syn;
      r.fin_flag = fin;
      r.retransmit = rtx;
      batch.push_back(r);
    endfunction

    // Emit segments until the window or the queue is full, nothing is left to send or the FIN goes
    function void send_window();
      longint unsigned win, syn, room, pay, fin, len;
      int unsigned slot;
      win = (win_last != 0) ? win_last : 1;
      while (win > outstanding && count < QUEUE_DEPTH_DEF && batch.size() < 64) begin
        syn = syn_sent ? 0 : 1;
        room = win - outstanding - syn;
        pay = room;
        fin = 0;
        if (pay > max_pay) pay = max_pay;
        if (pay > buffered) pay = buffered;
        if (!fin_sent && ended && buffered == pay && room - pay >= 1) fin = 1;
        if (pay == 0 && syn == 0 && fin == 0) break;
        syn_sent = 1;
        if (fin != 0) fin_sent = 1;
        if (count == 0) begin
          timer = 0;
          timeout = init_to;
        end
        slot = (head + count) % QUEUE_DEPTH_DEF;
        q_start[slot] = next_abs; q_pay[slot] = pay;
        q_syn[slot] = syn[0]; q_fin[slot] = fin[0];
        count++;
        add_seg(1, next_abs, pay, syn[0], fin[0], 0);
        len = pay + syn + fin;
        outstanding += len;
        next_abs = (next_abs + len) & 64'hFFFF_FFFF_FFFF;
        buffered -= pay;
        if (fin != 0) break;
      end
    endfunction

    // Note an accepted input and predict its results
    function void note_item(logic [2:0] kind, logic [15:0] wcnt, logic wend,
                            logic [31:0] ack, logic [15:0] wnd, logic [31:0] elapsed);
      longint unsigned space, diff, back, abs_ack, len, t;
      bit ok;
      batch.delete();
      case (kind)
        KIND_WRITE: begin
          if (!ended) begin
            space = (capacity > buffered) ? capacity - buffered : 0;
            buffered += (wcnt < space) ? wcnt : space;
          end
          if (wend) ended = 1;
        end
        KIND_FILL: send_window();
        KIND_ACK: begin
          diff = (ack - wrap_seq(next_abs)) & 64'hFFFF_FFFF;
          ok = 1;
          abs_ack = next_abs;
          if (diff != 0) begin
            if (diff < 64'h8000_0000) ok = 0;
            else begin
              back = 64'h1_0000_0000 - diff;
              if (back > next_abs) ok = 0;
              else abs_ack = next_abs - back;
            end
          end
          if (ok) begin
            while (count > 0) begin
              len = q_pay[head] + q_syn[head] + q_fin[head];
              if (abs_ack < q_start[head] + len) break;
              outstanding -= len;
              head = (head + 1) % QUEUE_DEPTH_DEF;
              count--;
              timer = 0;
              timeout = init_to;
            end
            retx = 0;
            win_last = wnd;
            send_window();
          end
        end
        KIND_TICK: begin
          t = timer + elapsed;
          timer = (t > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : t;
          if (count > 0 && timer >= timeout) begin
            timer = 0;
            add_seg(1, q_start[head], q_pay[head], q_syn[head], q_fin[head], 1);
            if (win_last > 0)
              timeout = (timeout > 64'h7FFF_FFFF) ? 64'hFFFF_FFFF : timeout * 2;
            if (retx < 16'hFFFF) retx++;
          end
        end
        KIND_EMPTY: add_seg(1, next_abs, 0, 0, 0, 0);
        default: ;
      endcase
      if (batch.size() == 0) add_seg(0, 0, 0, 0, 0, 0);
      foreach (batch[i]) begin
        batch[i].last = (i == batch.size() - 1);
        batch[i].in_flight = outstanding[16:0];
        batch[i].retx_count = retx[15:0];
        expected_q.push_back(batch[i]);
      end
    endfunction

    function void cmp(string name, longint unsigned exp_v, longint unsigned act_v);
      if (exp_v != act_v) begin
        $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
        errors++;
      end
    endfunction

    // Check one accepted result against the oldest expectation
    function void check_result(res_t got);
      res_t e;
      if (expected_q.size() == 0) begin
        $error("result with nothing expected: seqno %0h", got.seqno);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      cmp("seg_valid", e.seg_valid, got.seg_valid);
      cmp("seqno", e.seqno, got.seqno);
      cmp("stream_offset", e.stream_offset, got.stream_offset);
      cmp("payload_len", e.payload_len, got.payload_len);
      cmp("syn_flag", e.syn_flag, got.syn_flag);
      cmp("fin_flag", e.fin_flag, got.fin_flag);
      cmp("retransmit", e.retransmit, got.retransmit);
      cmp("last", e.last, got.last);
      cmp("in_flight", e.in_flight, got.in_flight);
      cmp("retx_count", e.retx_count, got.retx_count);
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [2:0]  kind_i = '0;
  logic [15:0] write_count_i = '0;
  logic        write_end_i = 1'b0;
  logic [31:0] ack_number_i = '0;
  logic [15:0] window_advert_i = '0;
  logic [31:0] elapsed_ms_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        seg_valid_o, syn_flag_o, fin_flag_o, retransmit_o, last_o;
  logic [31:0] seqno_o;
  logic [47:0] stream_offset_o;
  logic [15:0] payload_len_o;
  logic [16:0] in_flight_o;
  logic [15:0] retx_count_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  seg_scoreboard sb = new();
  int unsigned send_idle_pct = 25;
  int unsigned recv_idle_pct = 68;
  bit activity;
  int unsigned quiet_cycles;
  localparam int unsigned WATCHDOG_LIMIT = 5000;

  always #1 clk_i = ~clk_i;

  tcp_sender_window_retransmit i_dut (.*);

  // Drive result ready and check every result transfer
  initial begin : result_monitor
    res_t got;
    bit taken;
    forever begin
      @(negedge clk_i);
      out_ready_i = rst_ni && ($urandom_range(99) >= recv_idle_pct);
      #0.5;
      taken = out_valid_o && out_ready_i;
      got = '{seg_valid_o, seqno_o, stream_offset_o, payload_len_o, syn_flag_o,
              fin_flag_o, retransmit_o, last_o, in_flight_o, retx_count_o};
      @(posedge clk_i);
      if (taken) begin
        sb.check_result(got);
        activity = 1;
      end
    end
  end

  // End the run when nothing transfers for too long
  initial begin : watchdog
    quiet_cycles = 0;
    forever begin
      @(negedge clk_i);
      if (activity) quiet_cycles = 0;
      else quiet_cycles++;
      activity = 0;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Hand one item to the block and note it once transferred
  task automatic send_item(logic [2:0] kind, logic [15:0] wcnt, logic wend,
                           logic [31:0] ack, logic [15:0] wnd, logic [31:0] elapsed);
    bit done;
    while ($urandom_range(99) < send_idle_pct) @(negedge clk_i);
    in_valid_i = 1'b1;
    kind_i = kind; write_count_i = wcnt; write_end_i = wend;
    ack_number_i = ack; window_advert_i = wnd; elapsed_ms_i = elapsed;
    done = 0;
    while (!done) begin
      #0.5;
      done = in_ready_o;
      @(posedge clk_i);
      if (done) begin
        sb.note_item(kind, wcnt, wend, ack, wnd, elapsed);
        activity = 1;
      end
      @(negedge clk_i);
    end
    in_valid_i = 1'b0;
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    bit done;
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = val;
    done = 0;
    while (!done) begin
      #0.5;
      done = cfg_ready_o;
      @(posedge clk_i);
      if (done) begin
        sb.set_reg(idx, val);
        activity = 1;
      end
      @(negedge clk_i);
    end
    cfg_valid_i = 1'b0;
  endtask

  // Hold off until every expected result has come, then let the block settle
  task automatic drain();
    while (sb.expected_q.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  // Wrapped sequence number of the next unsent byte
  function automatic logic [31:0] next_seq();
    return 32'(sb.wrap_seq(sb.next_abs));
  endfunction

  // Ack number somewhere between the oldest unacked byte and the next seqno
  function automatic logic [31:0] good_ack();
    longint unsigned back;
    back = $urandom_range(32'(sb.outstanding), 0);
    return 32'(sb.wrap_seq(sb.next_abs - back));
  endfunction

  task automatic random_item(bit allow_end);
    int unsigned pick;
    logic [15:0] wcnt;
    logic [31:0] el;
    logic [15:0] wnd;
    longint unsigned el_max;
    pick = $urandom_range(99);
    wcnt = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(3000));
    el_max = sb.timeout * 3 / 2 + 2;
    if (el_max > 64'hFFFF_FFFF) el_max = 64'hFFFF_FFFF;
    el = ($urandom_range(7) == 0) ? $urandom : $urandom_range(32'(el_max));
    wnd = ($urandom_range(4) == 0) ? 16'($urandom_range(3)) : 16'($urandom);
    if (pick < 20)
      send_item(KIND_WRITE, wcnt, allow_end && ($urandom_range(19) == 0),
                $urandom, 16'($urandom), $urandom);
    else if (pick < 35)
      send_item(KIND_FILL, 16'($urandom), 1'b0, $urandom, 16'($urandom), $urandom);
    else if (pick < 65)
      send_item(KIND_ACK, 16'($urandom), 1'b0, good_ack(), wnd, $urandom);
    else if (pick < 70)
      send_item(KIND_ACK, 16'($urandom), 1'b0, $urandom, 16'($urandom), $urandom);
    else if (pick < 90)
      send_item(KIND_TICK, 16'($urandom), 1'b0, $urandom, 16'($urandom), el);
    else if (pick < 95)
      send_item(KIND_EMPTY, 16'($urandom), 1'b0, $urandom, 16'($urandom), $urandom);
    else
      send_item(3'($urandom_range(7, 5)), 16'($urandom), 1'($urandom), $urandom,
                16'($urandom), $urandom);
  endtask

  initial begin : stimulus
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: edges of the fields and the special cases
    send_item(KIND_EMPTY, 0, 0, 0, 0, 0);
    send_item(KIND_TICK, 0, 0, 0, 0, 0);
    send_item(KIND_ACK, 0, 0, 32'd5, 16'hFFFF, 0);
    send_item(KIND_ACK, 0, 0, 32'h8000_0000, 16'hFFFF, 0);
    send_item(KIND_FILL, 0, 0, 0, 0, 0);
    send_item(KIND_WRITE, 16'hFFFF, 0, 0, 0, 0);
    send_item(KIND_WRITE, 16'd100, 0, 0, 0, 0);
    send_item(3'd5, 16'hFFFF, 1, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
    send_item(3'd6, 0, 0, 0, 0, 0);
    send_item(3'd7, 0, 0, 0, 0, 0);
    send_item(KIND_ACK, 0, 0, 32'd1, 16'd0, 0);
    send_item(KIND_TICK, 0, 0, 0, 0, 32'hFFFF_FFFF);
    send_item(KIND_TICK, 0, 0, 0, 0, 32'hFFFF_FFFF);
    send_item(KIND_ACK, 0, 0, good_ack(), 16'hFFFF, 0);
    send_item(KIND_ACK, 0, 0, next_seq(), 16'hFFFF, 0);
    send_item(KIND_EMPTY, 0, 0, 0, 0, 0);
    send_item(KIND_ACK, 0, 0, 32'd1, 16'd3000, 0);
    send_item(KIND_ACK, 0, 0, next_seq() + 32'd1, 16'd3000, 0);
    send_item(KIND_ACK, 0, 0, next_seq(), 16'd3000, 0);
    repeat (40) random_item(0);

    // Wrap the sequence space, one-byte segments, zero timeout, full capacity
    drain();
    write_reg(CFG_INITIAL_SEQNO, 32'hFFFF_FFF0);
    write_reg(CFG_INITIAL_TIMEOUT, 32'd0);
    write_reg(CFG_MAX_PAYLOAD, 32'd1);
    write_reg(CFG_STREAM_CAPACITY, 32'hFFFF_FFFF);
    send_item(KIND_WRITE, 16'hFFFF, 0, 0, 0, 0);
    send_item(KIND_ACK, 0, 0, next_seq(), 16'hFFFF, 0);
    send_item(KIND_TICK, 0, 0, 0, 0, 0);
    repeat (40) random_item(0);
    send_idle_pct = 68;
    recv_idle_pct = 25;
    repeat (20) random_item(0);

    // Largest segments and timeout, capacity below the buffered bytes
    drain();
    write_reg(CFG_INITIAL_SEQNO, $urandom);
    write_reg(CFG_INITIAL_TIMEOUT, 32'hFFFF);
    write_reg(CFG_MAX_PAYLOAD, 32'hFFFF);
    write_reg(CFG_STREAM_CAPACITY, 32'd1);
    send_item(KIND_WRITE, 16'd500, 0, 0, 0, 0);
    repeat (60) random_item(0);

    // Typical settings, then end of input and FIN
    drain();
    write_reg(CFG_INITIAL_SEQNO, 32'h7FFF_FFFF);
    write_reg(CFG_INITIAL_TIMEOUT, 32'd3);
    write_reg(CFG_MAX_PAYLOAD, 32'd536);
    write_reg(CFG_STREAM_CAPACITY, 32'd200000);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (40) random_item(1);
    send_item(KIND_WRITE, 16'd700, 1, 0, 0, 0);
    send_item(KIND_WRITE, 16'd50, 0, 0, 0, 0);
    send_item(KIND_ACK, 0, 0, next_seq(), 16'hFFFF, 0);
    send_item(KIND_FILL, 0, 0, 0, 0, 0);
    send_item(KIND_ACK, 0, 0, next_seq(), 16'hFFFF, 0);
    send_item(KIND_TICK, 0, 0, 0, 0, 32'd10);

    drain();
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/tswr_pkg.sv
hdl/tswr_seg_mem.sv
hdl/tswr_ctrl.sv
hdl/tcp_sender_window_retransmit.sv
verif/tb_top.sv
